FILE: src/kst_pkg.sv
`timescale 1ns / 1ps
package kst_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int DATA_W = 64;

	// command codes
	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BELOW = 2'd1;
	localparam logic [1:0] ST_ABOVE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// value width codes
	localparam logic [1:0] KIND_8  = 2'd0;
	localparam logic [1:0] KIND_16 = 2'd1;
	localparam logic [1:0] KIND_32 = 2'd2;
	localparam logic [1:0] KIND_64 = 2'd3;

	// request word
	typedef struct packed {
		logic [1:0]          command;
		logic signed [63:0]  key;
		logic                key_is_null;
		logic signed [63:0]  value;
		logic                value_is_null;
	} req_t;

	// response word
	typedef struct packed {
		logic [1:0]          status;
		logic                entry_valid;
		logic signed [63:0]  out_key;
		logic signed [63:0]  out_sum;
		logic                last;
	} rsp_t;

	// sign-extend from the configured value width
	function automatic logic [63:0] sext_kind(input logic [63:0] v, input logic [1:0] kind);
		logic [63:0] r;
		case (kind)
			KIND_8:  r = {{56{v[7]}}, v[7:0]};
			KIND_16: r = {{48{v[15]}}, v[15:0]};
			KIND_32: r = {{32{v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	// sign bit at the configured value width
	function automatic logic sign_kind(input logic [63:0] v, input logic [1:0] kind);
		logic r;
		case (kind)
			KIND_8:  r = v[7];
			KIND_16: r = v[15];
			KIND_32: r = v[31];
			default: r = v[63];
		endcase
		return r;
	endfunction

endpackage

FILE: src/kst_ram.sv
`timescale 1ns / 1ps
module kst_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/kst_alu.sv
`timescale 1ns / 1ps
module kst_alu (
	input  logic [1:0]  kind,
	input  logic [63:0] acc,
	input  logic [63:0] addend,
	output logic [63:0] sum,
	output logic        ovf,
	output logic [1:0]  ovf_status
);
	import kst_pkg::*;

	logic [63:0] a;
	logic [63:0] b;
	logic        sa;
	logic        sb;
	logic        sr;

	// both operands reread at the configured width
	assign a = sext_kind(acc, kind);
	assign b = sext_kind(addend, kind);
	assign sum = a + b;

	// overflow at width w: same operand signs, result sign differs
	assign sa = sign_kind(a, kind);
	assign sb = sign_kind(b, kind);
	assign sr = sign_kind(sum, kind);
	assign ovf = (sa == sb) && (sr != sa);
	assign ovf_status = sa ? ST_BELOW : ST_ABOVE;

endmodule

FILE: src/keyed_sum_aggregation_table.sv
`timescale 1ns / 1ps
// add: key scan reads one entry per cycle from the key memory; a found key goes to the
//   update state, a new key or an empty table to the insert state, then the response state
// extract: per entry a memory read, then an output word once the output register is free
// clear, null key, empty extract: one word from the response state; unused command: no word
// one item at a time: next item taken the cycle after its last word enters the output register
// reset: asynchronous, clears entry count, sets value width to 64 bit, no clearing pass
module keyed_sum_aggregation_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_data,
	input  logic          req_valid,
	output logic          req_ready,
	input  kst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kst_pkg::rsp_t rsp
);
	import kst_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;
	localparam logic [2:0] S_XRD  = 3'd5;
	localparam logic [2:0] S_XOUT = 3'd6;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [2:0]       state_q;
	logic [1:0]       kind_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             chk_v_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [1:0]       status_q;
	logic [63:0]      key_q;
	logic [63:0]      val_q;
	logic             vnull_q;
	logic [63:0]      sum_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             key_we;
	logic             sum_we;
	logic [IDX_W-1:0] wr_addr;
	logic [63:0]      sum_wdata;
	logic [63:0]      key_rdata;
	logic [63:0]      sum_rdata;
	logic [63:0]      alu_sum;
	logic             alu_ovf;
	logic [1:0]       alu_status;
	logic             out_free;
	logic             load_rsp;
	rsp_t             rsp_next;
	logic             take;
	logic             key_hit;
	logic             scan_last;
	logic             x_last;

	assign req_ready = (state_q == S_IDLE);
	assign take = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign key_hit = (key_rdata == key_q);
	assign scan_last = ((CNT_W'(chk_idx_q) + CNT_ONE) == count_q);
	assign x_last = ((ptr_q + CNT_ONE) == count_q);

	// key and sum memories share one address stream
	kst_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES), .ADDR_W(IDX_W)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_rdata)
	);

	kst_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_ENTRIES), .ADDR_W(IDX_W)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (wr_addr),
		.wdata (sum_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (sum_rdata)
	);

	// checked add of the matched sum
	kst_alu u_alu (
		.kind       (kind_q),
		.acc        (sum_q),
		.addend     (val_q),
		.sum        (alu_sum),
		.ovf        (alu_ovf),
		.ovf_status (alu_status)
	);

	// memory access and response word
	always_comb begin
		rd_en = 1'b0;
		rd_addr = ptr_q[IDX_W-1:0];
		key_we = 1'b0;
		sum_we = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		sum_wdata = vnull_q ? 64'd0 : sext_kind(val_q, kind_q);
		load_rsp = 1'b0;
		rsp_next = '{status: status_q, entry_valid: 1'b0, out_key: '0, out_sum: '0,
			last: 1'b1};
		case (state_q)
			S_SCAN: begin
				rd_en = (ptr_q != count_q);
			end
			S_UPD: begin
				if (!vnull_q && !alu_ovf) begin
					sum_we = 1'b1;
					wr_addr = hit_idx_q;
					sum_wdata = alu_sum;
				end
			end
			S_INS: begin
				if (count_q != CNT_FULL) begin
					key_we = 1'b1;
					sum_we = 1'b1;
				end
			end
			S_RESP: begin
				load_rsp = out_free;
			end
			S_XRD: begin
				rd_en = 1'b1;
			end
			S_XOUT: begin
				load_rsp = out_free;
				rsp_next = '{status: ST_OK, entry_valid: 1'b1, out_key: key_rdata,
					out_sum: sum_rdata, last: x_last};
			end
			default: begin
				load_rsp = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q <= KIND_64;
			count_q <= '0;
			ptr_q <= '0;
			chk_v_q <= 1'b0;
			chk_idx_q <= '0;
			hit_idx_q <= '0;
			status_q <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kind_q <= cfg_data;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						ptr_q <= '0;
						chk_v_q <= 1'b0;
						status_q <= ST_OK;
						case (req.command)
							CMD_ADD: begin
								if (req.key_is_null) begin
									state_q <= S_RESP;
								end else if (count_q == '0) begin
									state_q <= S_INS;
								end else begin
									state_q <= S_SCAN;
								end
							end
							CMD_EXTRACT: begin
								state_q <= (count_q == '0) ? S_RESP : S_XRD;
							end
							CMD_CLEAR: begin
								count_q <= '0;
								state_q <= S_RESP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						ptr_q <= ptr_q + CNT_ONE;
					end
					chk_v_q <= rd_en;
					chk_idx_q <= ptr_q[IDX_W-1:0];
					if (chk_v_q) begin
						if (key_hit) begin
							hit_idx_q <= chk_idx_q;
							state_q <= S_UPD;
						end else if (scan_last) begin
							state_q <= S_INS;
						end
					end
				end
				S_UPD: begin
					status_q <= (!vnull_q && alu_ovf) ? alu_status : ST_OK;
					state_q <= S_RESP;
				end
				S_INS: begin
					if (count_q == CNT_FULL) begin
						status_q <= ST_FULL;
					end else begin
						count_q <= count_q + CNT_ONE;
						status_q <= ST_OK;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_XRD: begin
					state_q <= S_XOUT;
				end
				S_XOUT: begin
					if (out_free) begin
						ptr_q <= ptr_q + CNT_ONE;
						state_q <= x_last ? S_IDLE : S_XRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item and response payload
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= req.key;
			val_q <= req.value;
			vnull_q <= req.value_is_null;
		end
		if (state_q == S_SCAN && chk_v_q) begin
			sum_q <= sum_rdata;
		end
		if (load_rsp) begin
			rsp_q <= rsp_next;
		end
	end

endmodule

FILE: tb/keyed_sum_aggregation_table_tb.sv
`timescale 1ns / 1ps
module keyed_sum_aggregation_table_tb;
	import kst_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam int IDLE_PCT = 38;
	localparam int SETTLE_CYCLES = 160;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FILL_KEYS = 70;
	// width setting of each random phase, phase 0 in the low bits
	localparam logic [11:0] PHASE_KINDS = {KIND_8, KIND_64, KIND_32, KIND_8, KIND_64, KIND_16};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_data = KIND_64;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// stimulus and scoreboard state
	req_t req_words[$];
	rsp_t due_rsp[$];
	logic req_fire = 1'b0;
	logic calm = 1'b0;
	int words_queued = 0;
	int words_sent = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// shadow of the aggregation table
	logic [63:0] shadow_keys [TABLE_ENTRIES];
	logic [63:0] shadow_sums [TABLE_ENTRIES];
	int shadow_count = 0;
	logic [1:0] width_kind = KIND_64;

	keyed_sum_aggregation_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	// keep the low bits of the given width, sign-extended
	function automatic logic [63:0] at_width(logic [63:0] v, logic [1:0] kind);
		int sh;
		sh = 64 - (8 << kind);
		return 64'($signed(v << sh) >>> sh);
	endfunction

	// update the shadow table for one accepted word and queue the words it should cause
	function automatic void aggregate_word(req_t w);
		rsp_t r;
		int hit;
		int i;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] s;
		logic ovf;
		r = '0;
		r.last = 1'b1;
		case (w.command)
			CMD_ADD: begin
				r.status = ST_OK;
				if (!w.key_is_null) begin
					hit = -1;
					for (i = 0; i < shadow_count; i++)
						if (hit < 0 && shadow_keys[i] == w.key)
							hit = i;
					if (hit < 0) begin
						if (shadow_count >= TABLE_ENTRIES) begin
							r.status = ST_FULL;
						end else begin
							shadow_keys[shadow_count] = w.key;
							shadow_sums[shadow_count] = w.value_is_null ? 64'd0 :
								at_width(w.value, width_kind);
							shadow_count++;
						end
					end else if (!w.value_is_null) begin
						a = at_width(shadow_sums[hit], width_kind);
						b = at_width(w.value, width_kind);
						s = a + b;
						if (width_kind == KIND_64)
							ovf = (a[63] == b[63]) && (s[63] != a[63]);
						else
							ovf = at_width(s, width_kind) != s;
						if (ovf)
							r.status = a[63] ? ST_BELOW : ST_ABOVE;
						else
							shadow_sums[hit] = s;
					end
				end
				due_rsp.insert(due_rsp.size(), r);
			end
			CMD_EXTRACT: begin
				if (shadow_count == 0) begin
					due_rsp.insert(due_rsp.size(), r);
				end else begin
					for (i = 0; i < shadow_count; i++) begin
						r.entry_valid = 1'b1;
						r.out_key = shadow_keys[i];
						r.out_sum = shadow_sums[i];
						r.last = (i == shadow_count - 1);
						due_rsp.insert(due_rsp.size(), r);
					end
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
				due_rsp.insert(due_rsp.size(), r);
			end
			default: begin
			end
		endcase
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	// random value: small, near the top, near the bottom, or anything; upper bits random
	function automatic logic [63:0] pick_value();
		int w;
		logic [63:0] raw;
		logic [63:0] low;
		logic [63:0] mask;
		w = 8 << width_kind;
		raw = {$urandom, $urandom};
		case ($urandom_range(3))
			0: low = 64'(int'($urandom_range(8)) - 4);
			1: low = (64'd1 << (w - 1)) - 64'd1 - 64'($urandom_range(3));
			2: low = (64'd1 << (w - 1)) + 64'($urandom_range(3));
			default: low = raw;
		endcase
		mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
		return (raw & ~mask) | (low & mask);
	endfunction

	task automatic queue_add(logic [63:0] key, logic [63:0] value, logic key_null,
			logic value_null);
		req_t w;
		w.command = CMD_ADD;
		w.key = key;
		w.value = value;
		w.key_is_null = key_null;
		w.value_is_null = value_null;
		req_words.insert(req_words.size(), w);
		words_queued++;
	endtask

	// non-add commands carry random payload bits that must not matter
	task automatic queue_cmd(logic [1:0] cmd);
		req_t w;
		w.command = cmd;
		w.key = {$urandom, $urandom};
		w.value = {$urandom, $urandom};
		w.key_is_null = 1'($urandom_range(1));
		w.value_is_null = 1'($urandom_range(1));
		req_words.insert(req_words.size(), w);
		words_queued++;
	endtask

	// wait until every word is taken and answered, then let the block go quiet
	task automatic settle();
		do @(negedge clk); while (words_sent != words_queued || due_rsp.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_width(logic [1:0] kind);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= kind;
		@(negedge clk);
		cfg_we <= 1'b0;
		width_kind = kind;
		@(posedge clk);
	endtask

	// request driver and response back-pressure
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			if (!req_valid || req_fire) begin
				if (req_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					req <= req_words.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// response checker and request capture
	always @(posedge clk) begin
		rsp_t want;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			cycle_count++;
			req_fire <= arst_n && req_valid && req_ready;
			if (arst_n) begin
				if (rsp_valid && rsp_ready) begin
					if (due_rsp.size() == 0) begin
						$error("response word with nothing expected");
						mismatch_count++;
					end else begin
						want = due_rsp.pop_front();
						check_field("status", want.status, rsp.status);
						check_field("entry_valid", want.entry_valid, rsp.entry_valid);
						check_field("out_key", want.out_key, rsp.out_key);
						check_field("out_sum", want.out_sum, rsp.out_sum);
						check_field("last", want.last, rsp.last);
					end
				end
				if (req_valid && req_ready) begin
					aggregate_word(req);
					words_sent++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [63:0] key_pool [8];
		logic [63:0] fill_keys [FILL_KEYS];
		int p;
		int n;
		int pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, 64-bit extremes, nulls, overflow both ways
		queue_cmd(CMD_EXTRACT);
		queue_cmd(CMD_CLEAR);
		queue_add(64'd0, 64'd1, 1'b0, 1'b0);
		queue_add('1, MAX64, 1'b0, 1'b0);
		queue_add(MIN64, 64'h55, 1'b0, 1'b1);
		queue_add(MAX64, MIN64, 1'b0, 1'b0);
		queue_add(64'h1234, 64'd7, 1'b1, 1'b0);
		queue_add('1, 64'd1, 1'b0, 1'b0);
		queue_add(MAX64, '1, 1'b0, 1'b0);
		queue_add(64'd0, 64'd99, 1'b0, 1'b1);
		queue_add(MIN64, -64'sd5, 1'b0, 1'b0);
		queue_cmd(CMD_UNUSED);
		queue_cmd(CMD_EXTRACT);

		// directed: 8-bit width, ignored upper bits, stored sums reread narrow
		set_width(KIND_8);
		queue_add(64'd5, 64'h17f, 1'b0, 1'b0);
		queue_add(64'd5, 64'd1, 1'b0, 1'b0);
		queue_add(64'd6, 64'hffff_ff80, 1'b0, 1'b0);
		queue_add(64'd6, '1, 1'b0, 1'b0);
		queue_add('1, 64'd0, 1'b0, 1'b0);
		queue_add(MIN64, 64'h7f, 1'b0, 1'b0);
		queue_cmd(CMD_EXTRACT);
		queue_cmd(CMD_CLEAR);
		queue_cmd(CMD_EXTRACT);

		// random phases, one width setting each; the table carries over between them
		for (p = 0; p < 6; p++) begin
			set_width(PHASE_KINDS[2*p +: 2]);
			if (p == 1) begin
				// fill past capacity with no idling, then hit full and existing keys
				calm = 1'b1;
				for (n = 0; n < FILL_KEYS; n++) begin
					fill_keys[n] = {$urandom, $urandom};
					queue_add(fill_keys[n], pick_value(), 1'b0, $urandom_range(9) == 0);
				end
				queue_cmd(CMD_EXTRACT);
				for (n = 0; n < 12; n++) begin
					if (n % 2 == 0)
						queue_add(fill_keys[$urandom_range(FILL_KEYS - 1)], pick_value(),
							1'b0, 1'b0);
					else
						queue_add({$urandom, $urandom}, pick_value(), 1'b0, n % 3 == 1);
				end
				queue_cmd(CMD_EXTRACT);
				settle();
				calm = 1'b0;
			end else begin
				for (n = 0; n < 8; n++)
					key_pool[n] = $urandom_range(1) ? {$urandom, $urandom} :
						64'(int'($urandom_range(20)) - 10);
				for (n = 0; n < 41; n++) begin
					pick = $urandom_range(99);
					if (pick < 80)
						queue_add(($urandom_range(6) == 0) ? {$urandom, $urandom} :
							key_pool[$urandom_range(7)], pick_value(),
							$urandom_range(15) == 0, $urandom_range(11) == 0);
					else if (pick < 90)
						queue_cmd(CMD_EXTRACT);
					else if (pick < 95)
						queue_cmd(CMD_CLEAR);
					else
						queue_cmd(CMD_UNUSED);
				end
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: keyed_sum_aggregation_table.f
src/kst_pkg.sv
src/kst_ram.sv
src/kst_alu.sv
src/keyed_sum_aggregation_table.sv
tb/keyed_sum_aggregation_table_tb.sv
